// ===== hdl/srma_pkg.sv =====
// Shared constants and types for the spike-reject median/average filter.
`default_nettype none

package srma_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int DIFF_W            = 16;
    localparam int RUN_W             = 8;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 16;
    localparam int DEF_MEDIAN_DEPTH  = 5;
    localparam int DEF_AVERAGE_DEPTH = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DIFF_MAX = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ABN_MAX  = 2'd1;

    localparam logic [DIFF_W-1:0] DIFF_MAX_RESET = 16'd100;
    localparam logic [RUN_W-1:0]  ABN_MAX_RESET  = 8'd3;

    // Flags from the shared subtractor.
    typedef struct packed {
        logic borrow;
        logic zero;
    } alu_flags_t;

endpackage

`default_nettype wire

// ===== hdl/srma_alu.sv =====
// Shared subtract/compare unit: diff = a - b with borrow and zero flags.
`default_nettype none

module srma_alu #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0]       a,
    input  logic [WIDTH-1:0]       b,
    output logic [WIDTH-1:0]       diff,
    output srma_pkg::alu_flags_t   flags
);
    import srma_pkg::*;

    logic [WIDTH:0] full;

    assign full         = {1'b0, a} - {1'b0, b};
    assign diff         = full[WIDTH-1:0];
    assign flags.borrow = full[WIDTH];
    assign flags.zero   = (full[WIDTH-1:0] == '0);

endmodule

`default_nettype wire

// ===== hdl/srma_avg.sv =====
// Moving-average store: sample memory, running sum and fill count.
`default_nettype none

module srma_avg #(
    parameter int AVERAGE_DEPTH = srma_pkg::DEF_AVERAGE_DEPTH,
    parameter int SUM_W         = srma_pkg::SAMPLE_W + $clog2(AVERAGE_DEPTH),
    parameter int FILL_W        = $clog2(AVERAGE_DEPTH + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [srma_pkg::SAMPLE_W-1:0] push_value,
    output logic [SUM_W-1:0]              sum,
    output logic [FILL_W-1:0]             fill
);
    import srma_pkg::*;

    localparam int PW = $clog2(AVERAGE_DEPTH);

    logic [SAMPLE_W-1:0] mem [AVERAGE_DEPTH];
    logic [SAMPLE_W-1:0] old_reg;
    logic [PW-1:0]       pos_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                full;

    assign full = (fill_reg == FILL_W'(AVERAGE_DEPTH));

    // Entry under pos is read every cycle, so it is ready well before the push.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[pos_reg] <= push_value;
        end
        old_reg <= mem[pos_reg];
    end

    always_comb
    begin
        if (full)
        begin
            sum_next = sum_reg - SUM_W'(old_reg) + SUM_W'(push_value);
        end
        else
        begin
            sum_next = sum_reg + SUM_W'(push_value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
        end
        else if (push)
        begin
            sum_reg <= sum_next;
            if (!full)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (pos_reg == PW'(AVERAGE_DEPTH - 1))
            begin
                pos_reg <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

endmodule

`default_nettype wire

// ===== hdl/spike_reject_median_then_average_core.sv =====
// Top level: spike check, median by rank search, moving average with divider.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+--------------------------------------
//  s_       | in  | s_tvalid / s_tready | s_tdata[15:0] sample
//  m_       | out | m_tvalid / m_tready | m_tdata smoothed, median_value; m_tuser rejected
//  cfg_     | in  | cfg_we              | cfg_index, cfg_data
//
// A kept sample goes through the rank search, the average push and the divide; a dropped
// sample skips the rank search. The rank search runs one compare per cycle and the
// divide one quotient bit per cycle, both on the shared subtractor.
// Reset empties both stores at once through their fill counts; no clearing pass.
// s_tready is high only while idle; a result waiting in the output register
// does not block acceptance, only the final load of the next result.
`default_nettype none

module spike_reject_median_then_average_core #(
    parameter int MEDIAN_DEPTH  = srma_pkg::DEF_MEDIAN_DEPTH,
    parameter int AVERAGE_DEPTH = srma_pkg::DEF_AVERAGE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [15:0] sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [15:0] smoothed, [31:16] median_value
    output logic                             m_tuser,   // [0] rejected
    input  logic                             cfg_we,
    input  logic [srma_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srma_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import srma_pkg::*;

    localparam int MFW   = $clog2(MEDIAN_DEPTH + 1);
    localparam int CW    = $clog2(MEDIAN_DEPTH);
    localparam int FW    = $clog2(AVERAGE_DEPTH + 1);
    localparam int SW    = SAMPLE_W + $clog2(AVERAGE_DEPTH);
    localparam int DCW   = $clog2(SAMPLE_W);
    localparam int UW    = (SAMPLE_W > FW + 1) ? SAMPLE_W : FW + 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_CMP  = 7'b0000100,
        S_PUSH = 7'b0001000,
        S_PREP = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [DIFF_W-1:0]   diff_max_reg;
    logic [RUN_W-1:0]    abn_max_reg;
    logic [RUN_W-1:0]    run_reg;
    logic [MFW-1:0]      mfill_reg;
    logic [SAMPLE_W-1:0] last_median_reg;

    logic [SAMPLE_W-1:0] ring_reg [MEDIAN_DEPTH];
    logic [SAMPLE_W-1:0] work_reg [MEDIAN_DEPTH];
    logic [MEDIAN_DEPTH-1:0] work_vld_reg;
    logic [SAMPLE_W-1:0] cand_reg;
    logic                cand_vld_reg;
    logic [MFW-1:0]      lt_reg, le_reg, k_reg;
    logic [MFW-1:0]      lt_next, le_next;
    logic [CW-1:0]       cmp_cnt_reg;
    logic [DCW-1:0]      div_cnt_reg;

    logic [SAMPLE_W-1:0] median_reg;
    logic                rej_reg;
    logic [FW-1:0]       rem_reg;
    logic [SAMPLE_W-1:0] q_reg;

    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] out_smooth_reg, out_median_reg;
    logic                out_rej_reg;

    logic                accept;
    logic [SAMPLE_W-1:0] sample;
    logic [DIFF_W-1:0]   spike_delta;
    logic                outlier;
    logic [RUN_W-1:0]    run_inc;
    logic                drop;
    logic [MFW-1:0]      mfill_new;
    logic                found;
    logic                out_free;
    logic [SW-1:0]       dividend;

    logic [UW-1:0]       alu_a, alu_b, alu_diff;
    alu_flags_t          alu_flags;

    logic                avg_push;
    logic [SW-1:0]       avg_sum;
    logic [FW-1:0]       avg_fill;

    srma_alu #(.WIDTH(UW)) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .diff  (alu_diff),
        .flags (alu_flags)
    );

    srma_avg #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH),
        .SUM_W         (SW),
        .FILL_W        (FW)
    ) u_avg (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (avg_push),
        .push_value (median_reg),
        .sum        (avg_sum),
        .fill       (avg_fill)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign sample   = s_tdata[SAMPLE_W-1:0];
    assign avg_push = (state_reg == S_PUSH);
    assign out_free = !m_valid_reg || m_tready;

    // Spike check against the last median
    assign spike_delta = (sample > last_median_reg) ? (sample - last_median_reg)
                                                    : (last_median_reg - sample);
    assign outlier = (mfill_reg != '0) && (spike_delta > diff_max_reg);
    assign run_inc = run_reg + 1'b1;
    assign drop    = outlier && (run_inc < abn_max_reg);
    assign mfill_new = (mfill_reg == MFW'(MEDIAN_DEPTH)) ? mfill_reg : mfill_reg + 1'b1;

    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            alu_a = UW'({rem_reg, q_reg[SAMPLE_W-1]});
            alu_b = UW'(avg_fill);
        end
        else
        begin
            alu_a = UW'(work_reg[0]);
            alu_b = UW'(cand_reg);
        end
    end

    // Candidate is the median when fewer than k+1 entries are below it
    // and more than k are at or below it.
    assign lt_next = lt_reg + MFW'(work_vld_reg[0] & alu_flags.borrow);
    assign le_next = le_reg + MFW'(work_vld_reg[0] & (alu_flags.borrow | alu_flags.zero));
    assign found   = cand_vld_reg && (lt_next <= k_reg) && (le_next > k_reg);

    assign dividend = avg_sum + SW'(avg_fill >> 1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = drop ? S_PUSH : S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (cmp_cnt_reg == CW'(MEDIAN_DEPTH - 1))
                begin
                    state_next = found ? S_PUSH : S_LOAD;
                end
            end
            S_PUSH:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_cnt_reg == DCW'(SAMPLE_W - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            diff_max_reg    <= DIFF_MAX_RESET;
            abn_max_reg     <= ABN_MAX_RESET;
            run_reg         <= '0;
            mfill_reg       <= '0;
            last_median_reg <= '0;
            work_vld_reg    <= '0;
            cand_vld_reg    <= 1'b0;
            cmp_cnt_reg     <= '0;
            div_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DIFF_MAX: diff_max_reg <= cfg_data[DIFF_W-1:0];
                    REG_ABN_MAX:  abn_max_reg  <= cfg_data[RUN_W-1:0];
                    default:      ;
                endcase
            end

            // A new result may load in the same cycle the old one leaves
            if (state_reg == S_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (drop)
                        begin
                            run_reg <= run_inc;
                        end
                        else
                        begin
                            run_reg   <= '0;
                            mfill_reg <= mfill_new;
                            for (int i = 0; i < MEDIAN_DEPTH; i++)
                            begin
                                work_vld_reg[i] <= (MFW'(i) < mfill_new);
                            end
                        end
                    end
                end
                S_LOAD:
                begin
                    cand_vld_reg <= work_vld_reg[0];
                    work_vld_reg <= {work_vld_reg[0], work_vld_reg[MEDIAN_DEPTH-1:1]};
                    cmp_cnt_reg  <= '0;
                end
                S_CMP:
                begin
                    work_vld_reg <= {work_vld_reg[0], work_vld_reg[MEDIAN_DEPTH-1:1]};
                    cmp_cnt_reg  <= cmp_cnt_reg + 1'b1;
                    if (cmp_cnt_reg == CW'(MEDIAN_DEPTH - 1) && found)
                    begin
                        last_median_reg <= cand_reg;
                    end
                end
                S_PREP:
                begin
                    div_cnt_reg <= '0;
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rej_reg <= drop;
                    k_reg   <= mfill_new >> 1;
                    if (drop)
                    begin
                        median_reg <= last_median_reg;
                    end
                    else
                    begin
                        ring_reg[0] <= sample;
                        work_reg[0] <= sample;
                        for (int i = 1; i < MEDIAN_DEPTH; i++)
                        begin
                            ring_reg[i] <= ring_reg[i-1];
                            work_reg[i] <= ring_reg[i-1];
                        end
                    end
                end
            end
            S_LOAD:
            begin
                cand_reg <= work_reg[0];
                lt_reg   <= '0;
                le_reg   <= '0;
                for (int i = 0; i < MEDIAN_DEPTH; i++)
                begin
                    work_reg[i] <= work_reg[(i + 1) % MEDIAN_DEPTH];
                end
            end
            S_CMP:
            begin
                lt_reg <= lt_next;
                le_reg <= le_next;
                for (int i = 0; i < MEDIAN_DEPTH; i++)
                begin
                    work_reg[i] <= work_reg[(i + 1) % MEDIAN_DEPTH];
                end
                if (cmp_cnt_reg == CW'(MEDIAN_DEPTH - 1) && found)
                begin
                    median_reg <= cand_reg;
                end
            end
            S_PREP:
            begin
                // Quotient fits 16 bits, so the high part starts below the divisor.
                rem_reg <= FW'(dividend[SW-1:SAMPLE_W]);
                q_reg   <= dividend[SAMPLE_W-1:0];
            end
            S_DIV:
            begin
                if (alu_flags.borrow)
                begin
                    rem_reg <= FW'({rem_reg, q_reg[SAMPLE_W-1]});
                end
                else
                begin
                    rem_reg <= FW'(alu_diff);
                end
                q_reg <= {q_reg[SAMPLE_W-2:0], ~alu_flags.borrow};
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_smooth_reg <= q_reg;
                    out_median_reg <= median_reg;
                    out_rej_reg    <= rej_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_median_reg, out_smooth_reg};
    assign m_tuser  = out_rej_reg;

    a_rej_keeps_median: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && rej_reg) |-> (median_reg == last_median_reg))
        else $error("dropped sample did not repeat the last median");

    a_mfill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mfill_reg <= MFW'(MEDIAN_DEPTH))
        else $error("median fill count beyond ring depth");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < avg_fill))
        else $error("divider remainder not below fill count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready again right after accepting a request");

endmodule

`default_nettype wire
